/* sv/assert_macros.svh */
// Concurrent assertion helpers; clock and reset are taken by name from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

/* sv/i2cseq_pkg.sv */
package i2cseq_pkg;

   localparam int WRITE_DEPTH_DEF = 16;

   localparam logic [7:0] STATUS_MASK   = 8'hF8;
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_RSTART     = 8'h10;
   localparam logic [7:0] ST_WADDR_ACK  = 8'h18;
   localparam logic [7:0] ST_WADDR_NAK  = 8'h20;
   localparam logic [7:0] ST_WDATA_ACK  = 8'h28;
   localparam logic [7:0] ST_WDATA_NAK  = 8'h30;
   localparam logic [7:0] ST_RADDR_ACK  = 8'h40;
   localparam logic [7:0] ST_RADDR_NAK  = 8'h48;
   localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
   localparam logic [7:0] ST_RDATA_NAK  = 8'h58;

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_BEGIN = 2'd1,
      KIND_EVENT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_WSTART = 3'd1,
      PH_WADDR  = 3'd2,
      PH_WDATA  = 3'd3,
      PH_RSTART = 3'd4,
      PH_RADDR  = 3'd5,
      PH_RACK   = 3'd6,
      PH_RNACK  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_TX    = 3'd2,
      CMD_RXACK = 3'd3,
      CMD_RXNAK = 3'd4,
      CMD_STOP  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      OC_OK      = 2'd0,
      OC_NAK     = 2'd1,
      OC_UNEXPEC = 2'd2
   } outcome_type;

endpackage

/* sv/i2cseq_wbuf.sv */
module i2cseq_wbuf #(
   parameter int WRITE_DEPTH = i2cseq_pkg::WRITE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push_en,
   input  logic [7:0]                       push_data,
   input  logic                             clear,
   input  logic [$clog2(WRITE_DEPTH)-1:0]   rd_addr,
   output logic [7:0]                       rd_data
);

   localparam int AW = $clog2(WRITE_DEPTH);
   localparam int CW = $clog2(WRITE_DEPTH + 1);

   logic [7:0]    mem [WRITE_DEPTH];
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] fill_in;
   logic          wr_en;
   logic [7:0]    rd_data_ff;

   assign wr_en = push_en && (fill_ff != CW'(WRITE_DEPTH));

   always_comb begin
      fill_in = fill_ff;
      if (clear) begin
         fill_in = '0;
      end else if (wr_en) begin
         fill_in = fill_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[AW-1:0]] <= push_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/i2c_master_write_read_sequencer.sv */
// Channel | Ports                                   | Direction
// req     | req_valid/req_ready, kind and operands  | in
// rsp     | rsp_valid/rsp_ready, bus command/result | out
// Cycles: one transaction per clock while req_ready; any result appears the cycle after it.
// The result register takes a new result while the old one is consumed in the same cycle.
// Write data is prefetched from the buffer memory at the next send index into a read register.
// Reset: synchronous, returns the sequencer to idle and empties the write buffer.
// Stalls: req_ready drops only while a result is held and rsp_ready is low.
module i2c_master_write_read_sequencer #(
   parameter int WRITE_DEPTH = i2cseq_pkg::WRITE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [6:0]  req_dev_addr,
   input  logic [4:0]  req_write_count,
   input  logic [15:0] req_read_count,
   input  logic [7:0]  req_push_byte,
   input  logic [7:0]  req_bus_status,
   input  logic [7:0]  req_bus_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_bus_command,
   output logic [7:0]  rsp_tx_byte,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_rx_valid,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_outcome,
   output logic [7:0]  rsp_fail_status
);
   import i2cseq_pkg::*;
   `include "assert_macros.svh"

   localparam int AW = $clog2(WRITE_DEPTH);
   localparam int CW = $clog2(WRITE_DEPTH + 1);

   phase_type     phase_ff, phase_in;
   logic [CW-1:0] send_idx_ff, send_idx_in;
   logic [CW-1:0] to_write_ff, to_write_in;
   logic [15:0]   to_read_ff, to_read_in;
   logic [6:0]    target_ff, target_in;
   logic          wrote_ff, wrote_in;

   logic          rsp_valid_ff;
   cmd_type       cmd_ff;
   logic [7:0]    tx_ff, rx_ff, fs_ff;
   logic          rxv_ff, done_ff;
   outcome_type   oc_ff;

   logic          emit;
   cmd_type       cmd_in;
   logic [7:0]    tx_in, rx_in, fs_in;
   logic          rxv_in, done_in;
   outcome_type   oc_in;

   logic          acc;
   logic          push_en, clear;
   logic [7:0]    wr_byte;
   logic [7:0]    st;
   logic [CW-1:0] wc_sat;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign acc       = req_valid && req_ready;
   assign st        = req_bus_status & STATUS_MASK;

   always_comb begin
      if ({27'd0, req_write_count} > 32'(WRITE_DEPTH)) begin
         wc_sat = CW'(WRITE_DEPTH);
      end else begin
         wc_sat = CW'(req_write_count);
      end
   end

   i2cseq_wbuf #(
      .WRITE_DEPTH (WRITE_DEPTH)
   ) u_wbuf (
      .clock     (clock),
      .reset     (reset),
      .push_en   (push_en),
      .push_data (req_push_byte),
      .clear     (clear),
      .rd_addr   (send_idx_in[AW-1:0]),
      .rd_data   (wr_byte)
   );

   always_comb begin
      phase_in    = phase_ff;
      send_idx_in = send_idx_ff;
      to_write_in = to_write_ff;
      to_read_in  = to_read_ff;
      target_in   = target_ff;
      wrote_in    = wrote_ff;
      emit        = 1'b0;
      cmd_in      = CMD_NONE;
      tx_in       = '0;
      rx_in       = '0;
      rxv_in      = 1'b0;
      done_in     = 1'b0;
      oc_in       = OC_OK;
      fs_in       = '0;
      push_en     = 1'b0;
      clear       = 1'b0;
      if (acc) begin
         unique case (kind_type'(req_kind))
            KIND_PUSH: begin
               push_en = (phase_ff == PH_IDLE);
            end
            KIND_BEGIN: begin
               if (phase_ff == PH_IDLE) begin
                  clear       = 1'b1;
                  emit        = 1'b1;
                  target_in   = req_dev_addr;
                  to_write_in = wc_sat;
                  to_read_in  = req_read_count;
                  send_idx_in = '0;
                  wrote_in    = (wc_sat != '0);
                  if (wc_sat != '0) begin
                     phase_in = PH_WSTART;
                     cmd_in   = CMD_START;
                  end else if (req_read_count != '0) begin
                     phase_in = PH_RSTART;
                     cmd_in   = CMD_START;
                  end else begin
                     done_in = 1'b1;
                  end
               end
            end
            KIND_EVENT: begin
               if (phase_ff != PH_IDLE) begin
                  emit = 1'b1;
                  unique case (phase_ff)
                     PH_WSTART: begin
                        if (st == ST_START) begin
                           phase_in = PH_WADDR;
                           cmd_in   = CMD_TX;
                           tx_in    = {target_ff, 1'b0};
                        end else begin
                           oc_in = OC_UNEXPEC;
                        end
                     end
                     PH_WADDR: begin
                        if (st == ST_WADDR_ACK) begin
                           phase_in    = PH_WDATA;
                           cmd_in      = CMD_TX;
                           tx_in       = wr_byte;
                           send_idx_in = send_idx_ff + CW'(1);
                        end else begin
                           oc_in = (st == ST_WADDR_NAK) ? OC_NAK : OC_UNEXPEC;
                        end
                     end
                     PH_WDATA: begin
                        if (st != ST_WDATA_ACK) begin
                           oc_in = (st == ST_WDATA_NAK) ? OC_NAK : OC_UNEXPEC;
                        end else if (send_idx_ff < to_write_ff) begin
                           cmd_in      = CMD_TX;
                           tx_in       = wr_byte;
                           send_idx_in = send_idx_ff + CW'(1);
                        end else if (to_read_ff != '0) begin
                           phase_in = PH_RSTART;
                           cmd_in   = CMD_START;
                        end else begin
                           phase_in = PH_IDLE;
                           cmd_in   = CMD_STOP;
                           done_in  = 1'b1;
                        end
                     end
                     PH_RSTART: begin
                        if (st == (wrote_ff ? ST_RSTART : ST_START)) begin
                           phase_in = PH_RADDR;
                           cmd_in   = CMD_TX;
                           tx_in    = {target_ff, 1'b1};
                        end else begin
                           oc_in = OC_UNEXPEC;
                        end
                     end
                     PH_RADDR: begin
                        if (st == ST_RADDR_ACK) begin
                           if (to_read_ff > 16'd1) begin
                              phase_in = PH_RACK;
                              cmd_in   = CMD_RXACK;
                           end else begin
                              phase_in = PH_RNACK;
                              cmd_in   = CMD_RXNAK;
                           end
                        end else begin
                           oc_in = (st == ST_RADDR_NAK) ? OC_NAK : OC_UNEXPEC;
                        end
                     end
                     PH_RACK: begin
                        if (st == ST_RDATA_ACK) begin
                           to_read_in = to_read_ff - 16'd1;
                           rx_in      = req_bus_data;
                           rxv_in     = 1'b1;
                           if (to_read_in > 16'd1) begin
                              cmd_in = CMD_RXACK;
                           end else begin
                              phase_in = PH_RNACK;
                              cmd_in   = CMD_RXNAK;
                           end
                        end else begin
                           oc_in = OC_UNEXPEC;
                        end
                     end
                     PH_RNACK: begin
                        if (st == ST_RDATA_NAK) begin
                           phase_in   = PH_IDLE;
                           to_read_in = '0;
                           cmd_in     = CMD_STOP;
                           rx_in      = req_bus_data;
                           rxv_in     = 1'b1;
                           done_in    = 1'b1;
                        end else begin
                           oc_in = OC_UNEXPEC;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
                  if (oc_in != OC_OK) begin
                     phase_in = PH_IDLE;
                     cmd_in   = (oc_in == OC_NAK) ? CMD_STOP : CMD_NONE;
                     done_in  = 1'b1;
                     fs_in    = st;
                  end
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         send_idx_ff  <= '0;
         to_write_ff  <= '0;
         to_read_ff   <= '0;
         target_ff    <= '0;
         wrote_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         send_idx_ff <= send_idx_in;
         to_write_ff <= to_write_in;
         to_read_ff  <= to_read_in;
         target_ff   <= target_in;
         wrote_ff    <= wrote_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         cmd_ff  <= cmd_in;
         tx_ff   <= tx_in;
         rx_ff   <= rx_in;
         rxv_ff  <= rxv_in;
         done_ff <= done_in;
         oc_ff   <= oc_in;
         fs_ff   <= fs_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bus_command = 3'(cmd_ff);
   assign rsp_tx_byte     = tx_ff;
   assign rsp_rx_byte     = rx_ff;
   assign rsp_rx_valid    = rxv_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_outcome     = 2'(oc_ff);
   assign rsp_fail_status = fs_ff;

   `ASSERT_NEXT(a_done_idle, emit && done_in, phase_ff == PH_IDLE)
   `ASSERT_ALWAYS(a_idx_bound, send_idx_ff <= to_write_ff)
   `ASSERT_SAME(a_fail_done, rsp_valid_ff && (oc_ff != OC_OK), done_ff)
   `ASSERT_SAME(a_rx_cmd, rsp_valid_ff && rxv_ff,
                cmd_ff == CMD_RXACK || cmd_ff == CMD_RXNAK || cmd_ff == CMD_STOP)

endmodule
